// File: sv/dsa_pkg.sv
// Package for the descriptor slot allocator.
// Holds the request and response types, action codes and status codes.
// No dependencies.
package dsa_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int unsigned FirstSearchSlot = 2;

  typedef struct packed {
    action_e     action;
    logic [7:0]  slot_in;
    logic [31:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  slot_out;
    logic [31:0] handle_out;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic       found;
    logic       upper;
    logic [7:0] idx;
  } srch_res_t;

endpackage

// File: sv/dsa_handle_mem.sv
// Handle storage for the descriptor slot allocator.
// One write port and one read port with registered read data.
// Depends on nothing else.
module dsa_handle_mem #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem_q [SLOTS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dsa_free_search.sv
// Next-fit free slot search over the occupancy bitmap.
// A two-stage registered tree: per-group encoders, then a group select.
// Depends on dsa_pkg.
module dsa_free_search
  import dsa_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SLOTS-1:0]           occ_i,
  input  logic [$clog2(SLOTS+1)-1:0] hint_i,
  output logic                       done_o,
  output srch_res_t                  res_o
);

  localparam int unsigned GW   = 16;
  localparam int unsigned GIW  = $clog2(GW);
  localparam int unsigned NGRP = (SLOTS + GW - 1) / GW;
  localparam int unsigned PADW = NGRP * GW;
  localparam int unsigned HW   = $clog2(SLOTS + 1);

  logic [PADW-1:0] free_a;
  logic [PADW-1:0] free_b;
  logic [NGRP-1:0] any_a_d, any_b_d, any_a_q, any_b_q;
  logic [GIW-1:0]  first_a_d [NGRP];
  logic [GIW-1:0]  first_b_d [NGRP];
  logic [GIW-1:0]  first_a_q [NGRP];
  logic [GIW-1:0]  first_b_q [NGRP];
  logic            s1_q;
  logic            done_q;
  srch_res_t       res_d, res_q;
  logic [7:0]      idx_a, idx_b;

  always_comb begin
    free_a = '0;
    free_b = '0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      free_b[i] = !occ_i[i] && (i >= int'(FirstSearchSlot));
      free_a[i] = free_b[i] && (HW'(i) >= hint_i);
    end
  end

  always_comb begin
    for (int g = 0; g < int'(NGRP); g++) begin
      any_a_d[g]   = |free_a[g*GW +: GW];
      any_b_d[g]   = |free_b[g*GW +: GW];
      first_a_d[g] = '0;
      first_b_d[g] = '0;
      for (int b = int'(GW) - 1; b >= 0; b--) begin
        if (free_a[g*GW + b]) begin
          first_a_d[g] = GIW'(b);
        end
        if (free_b[g*GW + b]) begin
          first_b_d[g] = GIW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      any_a_q   <= any_a_d;
      any_b_q   <= any_b_d;
      first_a_q <= first_a_d;
      first_b_q <= first_b_d;
    end
  end

  always_comb begin
    idx_a = '0;
    idx_b = '0;
    for (int g = int'(NGRP) - 1; g >= 0; g--) begin
      if (any_a_q[g]) begin
        idx_a = 8'(g * int'(GW)) + 8'(first_a_q[g]);
      end
      if (any_b_q[g]) begin
        idx_b = 8'(g * int'(GW)) + 8'(first_b_q[g]);
      end
    end
    res_d.upper = |any_a_q;
    res_d.found = (|any_a_q) || (|any_b_q);
    res_d.idx   = res_d.upper ? idx_a : idx_b;
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/descriptor_slot_allocator_top.sv
// Descriptor slot allocator: a table of SLOTS handles with next-fit allocation.
// Handles sit in a one-port-read memory; an occupancy bitmap in flip-flops,
// cleared by reset, marks the filled slots, so no clearing pass is needed.
// One request is worked on at a time. An add with a nonzero handle passes the
// registered search tree over the bitmap (group register, then result register),
// is committed to memory and bitmap, and is then loaded into the output register;
// a get reads the memory and is then loaded, and a close, an add of a zero handle
// or an unknown action is loaded from the pending register. A result waits while
// the previous one is still held untaken. The next request is accepted once the
// result is loaded, even if that result has not yet been taken. Depends on dsa_pkg,
// dsa_handle_mem and dsa_free_search.
module descriptor_slot_allocator_top
  import dsa_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IDXW = $clog2(SLOTS);
  localparam int unsigned HW   = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_SRCH,
    S_RESP
  } state_e;

  state_e          state_q;
  req_t            req_q;
  rsp_t            pend_q;
  rsp_t            out_q;
  logic            out_valid_q;
  logic [SLOTS-1:0] occ_q;
  logic [HW-1:0]   hint_q;

  logic            in_accept;
  logic            in_range_in;
  logic            in_range_req;
  logic [IDXW-1:0] in_idx;
  logic [IDXW-1:0] req_idx;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;
  logic [31:0]     mem_rdata;
  logic            srch_start;
  logic            srch_done;
  srch_res_t       srch_res;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_accept    = in_valid_i && in_ready_o;
  assign in_range_in  = {1'b0, in_req_i.slot_in} < 9'(SLOTS);
  assign in_range_req = {1'b0, req_q.slot_in} < 9'(SLOTS);
  assign in_idx       = in_req_i.slot_in[IDXW-1:0];
  assign req_idx      = req_q.slot_in[IDXW-1:0];

  assign srch_start = in_accept && (in_req_i.action == ACT_ADD) &&
                      (in_req_i.handle_in != 32'd0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_idx;
    mem_wdata = 32'd0;
    if (in_accept && (in_req_i.action == ACT_CLOSE) && in_range_in) begin
      mem_we = 1'b1;
    end else if ((state_q == S_SRCH) && srch_done && srch_res.found) begin
      mem_we    = 1'b1;
      mem_waddr = srch_res.idx[IDXW-1:0];
      mem_wdata = req_q.handle_in;
    end
  end

  dsa_handle_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(in_idx),
    .rdata_o(mem_rdata)
  );

  dsa_free_search #(
    .SLOTS(SLOTS)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(srch_start),
    .occ_i  (occ_q),
    .hint_i (hint_q),
    .done_o (srch_done),
    .res_o  (srch_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      hint_q <= HW'(FirstSearchSlot);
    end else begin
      if (mem_we) begin
        occ_q[mem_waddr] <= (mem_wdata != 32'd0);
      end
      if ((state_q == S_SRCH) && srch_done && srch_res.found && srch_res.upper) begin
        hint_q <= HW'(srch_res.idx) + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            case (in_req_i.action)
              ACT_ADD: begin
                if (in_req_i.handle_in == 32'd0) begin
                  pend_q  <= '{slot_out: 8'd0, handle_out: 32'd0, status: STATUS_FAIL};
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              ACT_GET: begin
                state_q <= S_GET;
              end
              ACT_CLOSE: begin
                pend_q  <= '{slot_out: in_req_i.slot_in, handle_out: 32'd0,
                             status: in_range_in ? STATUS_OK : STATUS_FAIL};
                state_q <= S_RESP;
              end
              default: begin
                pend_q  <= '{slot_out: in_req_i.slot_in, handle_out: 32'd0,
                             status: STATUS_FAIL};
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_GET: begin
          pend_q.slot_out   <= req_q.slot_in;
          pend_q.handle_out <= (in_range_req && occ_q[req_idx]) ? mem_rdata : 32'd0;
          pend_q.status     <= in_range_req ? STATUS_OK : STATUS_FAIL;
          state_q           <= S_RESP;
        end
        S_SRCH: begin
          if (srch_done) begin
            if (srch_res.found) begin
              pend_q <= '{slot_out: srch_res.idx, handle_out: 32'd0, status: STATUS_OK};
            end else begin
              pend_q <= '{slot_out: 8'd0, handle_out: 32'd0, status: STATUS_FAIL};
            end
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
